### design/rotation_matrix_to_quaternion_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion block
// Concurrent implication checks clocked on the rising edge of a given clock.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef ASSERT_OFF
`define RMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/rmq_pkg.sv
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion package
// Widths, stage records and the case code shared by the pipeline modules.
// ---------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int DATA_WIDTH = 16;

    localparam int CW   = DATA_WIDTH + 2;
    localparam int SQW  = ((CW - 1 + FRAC_BITS - 2) + 1) / 2 * 2;
    localparam int RW   = SQW / 2;
    localparam int REMW = RW + 2;
    localparam int NUMW = DATA_WIDTH + 1;
    localparam int DVW  = NUMW + FRAC_BITS - 2;
    localparam int DIV_LAT = DVW + 2;

    localparam logic [DVW-1:0] ONE_Q = DVW'(1) << FRAC_BITS;
    localparam logic [RW-1:0]  ONE_R = RW'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        CASE_W = 2'd0,
        CASE_X = 2'd1,
        CASE_Y = 2'd2,
        CASE_Z = 2'd3
    } case_t;

    typedef struct packed {
        logic                   valid;
        logic [SQW-1:0]         n;
        logic [REMW-1:0]        rem;
        logic [RW-1:0]          root;
        logic [2:0][NUMW-1:0]   nums;
        case_t                  pick;
        logic                   bad;
    } sq_stage_t;

    typedef struct packed {
        logic                   valid;
        logic [DATA_WIDTH-1:0]  root_sat;
        case_t                  pick;
        logic                   bad;
    } meta_t;

    typedef struct packed {
        logic [RW:0]            rem;
        logic [DVW-1:0]         dvd;
        logic [DVW-1:0]         quo;
        logic [RW-1:0]          dsr;
        logic                   neg;
    } div_stage_t;

endpackage

### design/rotation_matrix_to_quaternion.sv
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion
// Picks the largest diagonal combination, takes its root and divides the
// off-diagonal sums and differences by four times that root, all in one deep pipeline.
// ---------------------------------------------------------------------------
// Channel  Direction  tdata                         tuser
// s_       in         m00..m22, 16 bits each        none
// m_       out        quat_w, quat_x, quat_y, quat_z  largest_case, invalid
//
// One item may enter in every cycle unless the output stalls; the pipeline is an
// input register, 15 root stages and 31 divider stages, set by the bit-serial
// root and quotient pipelines.
// Reset clears only the valid bits. A stall at the output freezes the whole
// pipeline, so no item is lost or repeated.
// ---------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [143:0]  s_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic [2:0]    m_tuser    // largest_case, invalid
);

    localparam int DW = rmq_pkg::DATA_WIDTH;
    localparam int CW = rmq_pkg::CW;
    localparam int RW = rmq_pkg::RW;
    localparam int NW = rmq_pkg::NUMW;
    localparam int ML = rmq_pkg::DIV_LAT;

    logic advance;
    logic signed [DW-1:0] a [0:8];
    logic signed [CW-1:0] comb [0:3];
    logic signed [CW-1:0] v;
    logic signed [NW-1:0] d_12_21, d_20_02, d_01_10, s_01_10, s_02_20, s_21_12;
    rmq_pkg::case_t pick;
    rmq_pkg::sq_stage_t sq_reg [0:RW];
    rmq_pkg::sq_stage_t sq_next [0:RW];
    rmq_pkg::meta_t md_reg [0:ML-1];
    rmq_pkg::meta_t md_next;
    logic signed [DW-1:0] lane_q [0:2];
    logic [DW-1:0] q [0:3];
    logic [RW-1:0] rsat;

    function automatic rmq_pkg::sq_stage_t sq_step(input rmq_pkg::sq_stage_t s);
        rmq_pkg::sq_stage_t r;
        logic [rmq_pkg::REMW-1:0] t;
        logic [rmq_pkg::REMW-1:0] trial;
        r = s;
        t = {s.rem[rmq_pkg::REMW-3:0], s.n[rmq_pkg::SQW-1:rmq_pkg::SQW-2]};
        trial = {s.root, 2'b01};
        r.n = {s.n[rmq_pkg::SQW-3:0], 2'b00};
        if (t >= trial) begin
            r.rem = t - trial;
            r.root = {s.root[rmq_pkg::RW-2:0], 1'b1};
        end else begin
            r.rem = t;
            r.root = {s.root[rmq_pkg::RW-2:0], 1'b0};
        end
        return r;
    endfunction

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            a[i] = $signed(s_tdata[i*DW +: DW]);
        end
        comb[0] = CW'(a[0]) + CW'(a[4]) + CW'(a[8]);
        comb[1] = CW'(a[0]) - CW'(a[4]) - CW'(a[8]);
        comb[2] = -CW'(a[0]) + CW'(a[4]) - CW'(a[8]);
        comb[3] = -CW'(a[0]) - CW'(a[4]) + CW'(a[8]);
        pick = rmq_pkg::CASE_W;
        v = comb[0];
        if (comb[1] > v) begin
            pick = rmq_pkg::CASE_X;
            v = comb[1];
        end
        if (comb[2] > v) begin
            pick = rmq_pkg::CASE_Y;
            v = comb[2];
        end
        if (comb[3] > v) begin
            pick = rmq_pkg::CASE_Z;
            v = comb[3];
        end
        v = v + CW'(1 <<< rmq_pkg::FRAC_BITS);
        d_12_21 = NW'(a[5]) - NW'(a[7]);
        d_20_02 = NW'(a[6]) - NW'(a[2]);
        d_01_10 = NW'(a[1]) - NW'(a[3]);
        s_01_10 = NW'(a[1]) + NW'(a[3]);
        s_02_20 = NW'(a[2]) + NW'(a[6]);
        s_21_12 = NW'(a[7]) + NW'(a[5]);

        sq_next[0].valid = s_tvalid;
        sq_next[0].bad   = (v <= 0);
        sq_next[0].pick  = pick;
        sq_next[0].rem   = '0;
        sq_next[0].root  = '0;
        sq_next[0].n     = (v <= 0) ? '0
                         : rmq_pkg::SQW'({v[CW-2:0], {(rmq_pkg::FRAC_BITS-2){1'b0}}});
        case (pick)
            rmq_pkg::CASE_W: sq_next[0].nums = {d_01_10, d_20_02, d_12_21};
            rmq_pkg::CASE_X: sq_next[0].nums = {s_02_20, s_01_10, d_12_21};
            rmq_pkg::CASE_Y: sq_next[0].nums = {s_21_12, s_01_10, d_20_02};
            default:         sq_next[0].nums = {s_21_12, s_02_20, d_01_10};
        endcase
        for (int i = 1; i <= RW; i++) begin
            sq_next[i] = sq_step(sq_reg[i-1]);
        end

        rsat = (sq_reg[RW].root > rmq_pkg::ONE_R) ? rmq_pkg::ONE_R : sq_reg[RW].root;
        md_next.valid    = sq_reg[RW].valid;
        md_next.root_sat = DW'(rsat);
        md_next.pick     = sq_reg[RW].pick;
        md_next.bad      = sq_reg[RW].bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= RW; i++) begin
                sq_reg[i].valid <= 1'b0;
            end
            for (int i = 0; i < ML; i++) begin
                md_reg[i].valid <= 1'b0;
            end
        end else if (advance) begin
            for (int i = 0; i <= RW; i++) begin
                sq_reg[i] <= sq_next[i];
            end
            md_reg[0] <= md_next;
            for (int i = 1; i < ML; i++) begin
                md_reg[i] <= md_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        rmq_div_lane u_lane (
            .aclk     (aclk),
            .en       (advance),
            .num      ($signed(sq_reg[RW].nums[k])),
            .root     (sq_reg[RW].root),
            .quot_reg (lane_q[k])
        );
    end

    always_comb begin
        case (md_reg[ML-1].pick)
            rmq_pkg::CASE_W: begin
                q[0] = md_reg[ML-1].root_sat;
                q[1] = lane_q[0];
                q[2] = lane_q[1];
                q[3] = lane_q[2];
            end
            rmq_pkg::CASE_X: begin
                q[0] = lane_q[0];
                q[1] = md_reg[ML-1].root_sat;
                q[2] = lane_q[1];
                q[3] = lane_q[2];
            end
            rmq_pkg::CASE_Y: begin
                q[0] = lane_q[0];
                q[1] = lane_q[1];
                q[2] = md_reg[ML-1].root_sat;
                q[3] = lane_q[2];
            end
            default: begin
                q[0] = lane_q[0];
                q[1] = lane_q[1];
                q[2] = lane_q[2];
                q[3] = md_reg[ML-1].root_sat;
            end
        endcase
        if (md_reg[ML-1].bad) begin
            for (int i = 0; i < 4; i++) begin
                q[i] = '0;
            end
        end
    end

    assign m_tvalid = md_reg[ML-1].valid;
    assign m_tdata  = {q[3], q[2], q[1], q[0]};
    assign m_tuser  = {md_reg[ML-1].bad, md_reg[ML-1].pick};

    `RMQ_ASSERT_IMPL(a_invalid_zero, aclk, aresetn, m_tvalid && m_tuser[2], m_tdata == 64'd0)
    `RMQ_ASSERT_IMPL(a_ready_rule, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready))
    `RMQ_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

### design/rmq_div_lane.sv
// ---------------------------------------------------------------------------
// Pipelined divider lane
// Restoring division, one quotient bit per stage, truncated toward zero
// and saturated to plus or minus one.
// ---------------------------------------------------------------------------
module rmq_div_lane (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [rmq_pkg::NUMW-1:0]       num,
    input  logic [rmq_pkg::RW-1:0]                root,
    output logic signed [rmq_pkg::DATA_WIDTH-1:0] quot_reg
);

    rmq_pkg::div_stage_t stage_reg [0:rmq_pkg::DVW];
    rmq_pkg::div_stage_t stage_next [0:rmq_pkg::DVW];
    logic [rmq_pkg::NUMW-1:0]       mag;
    logic [rmq_pkg::DVW-1:0]        qsat;
    logic [rmq_pkg::DATA_WIDTH-1:0] qmag;

    function automatic rmq_pkg::div_stage_t div_step(input rmq_pkg::div_stage_t s);
        rmq_pkg::div_stage_t r;
        logic [rmq_pkg::RW+1:0] t;
        r = s;
        t = {s.rem, s.dvd[rmq_pkg::DVW-1]};
        r.dvd = {s.dvd[rmq_pkg::DVW-2:0], 1'b0};
        if (t >= {2'b00, s.dsr}) begin
            r.rem = (rmq_pkg::RW+1)'(t - {2'b00, s.dsr});
            r.quo = {s.quo[rmq_pkg::DVW-2:0], 1'b1};
        end else begin
            r.rem = t[rmq_pkg::RW:0];
            r.quo = {s.quo[rmq_pkg::DVW-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        mag = num[rmq_pkg::NUMW-1] ? rmq_pkg::NUMW'(-num) : rmq_pkg::NUMW'(num);
        stage_next[0].rem = '0;
        stage_next[0].dvd = {mag, {(rmq_pkg::FRAC_BITS-2){1'b0}}};
        stage_next[0].quo = '0;
        stage_next[0].dsr = root;
        stage_next[0].neg = num[rmq_pkg::NUMW-1];
        for (int i = 1; i <= rmq_pkg::DVW; i++) begin
            stage_next[i] = div_step(stage_reg[i-1]);
        end
        qsat = (stage_reg[rmq_pkg::DVW].quo > rmq_pkg::ONE_Q) ? rmq_pkg::ONE_Q
                                                             : stage_reg[rmq_pkg::DVW].quo;
        qmag = qsat[rmq_pkg::DATA_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i <= rmq_pkg::DVW; i++) begin
                stage_reg[i] <= stage_next[i];
            end
            quot_reg <= stage_reg[rmq_pkg::DVW].neg ? $signed(-qmag) : $signed(qmag);
        end
    end

endmodule

### dv/rmq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quaternion conversion checker
// Watches both channels, works out the quaternion that each accepted matrix
// should give and compares every returned item with the oldest expectation.
// ---------------------------------------------------------------------------
module rmq_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [143:0]  s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [63:0]   m_tdata,
    input  logic [2:0]    m_tuser,
    output int            fail_count,
    output int            pending,
    output int            results_seen
);

    typedef struct packed {
        logic [15:0]     qw;
        logic [15:0]     qx;
        logic [15:0]     qy;
        logic [15:0]     qz;
        rmq_pkg::case_t  pick;
        logic            bad;
    } quat_t;

    localparam longint ONE = 64'sd1 << rmq_pkg::FRAC_BITS;

    quat_t quat_queue[$];

    function automatic longint isqrt(longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= n) begin
                r = r + (64'sd1 << b);
            end
        end
        return r;
    endfunction

    function automatic longint sat_one(longint v);
        if (v > ONE) begin
            return ONE;
        end
        if (v < -ONE) begin
            return -ONE;
        end
        return v;
    endfunction

    function automatic longint quot(longint num, longint r);
        return sat_one((num * ONE) / (4 * r));
    endfunction

    function automatic quat_t convert_matrix(logic [143:0] d);
        longint a[9];
        longint comb[4];
        longint q[4];
        longint v;
        longint r;
        int sel;
        quat_t res;
        for (int i = 0; i < 9; i++) begin
            a[i] = longint'($signed(d[16*i +: 16]));
        end
        // Index order: 0 m00, 1 m01, 2 m02, 3 m10, 4 m11, 5 m12, 6 m20, 7 m21, 8 m22.
        comb[0] = a[0] + a[4] + a[8];
        comb[1] = a[0] - a[4] - a[8];
        comb[2] = -a[0] + a[4] - a[8];
        comb[3] = -a[0] - a[4] + a[8];
        sel = 0;
        for (int i = 1; i < 4; i++) begin
            if (comb[i] > comb[sel]) begin
                sel = i;
            end
        end
        q = '{0, 0, 0, 0};
        v = comb[sel] + ONE;
        res.bad = (v <= 0);
        if (v > 0) begin
            r = isqrt(v << (rmq_pkg::FRAC_BITS - 2));
            case (sel)
                0: begin
                    q[0] = sat_one(r);
                    q[1] = quot(a[5] - a[7], r);
                    q[2] = quot(a[6] - a[2], r);
                    q[3] = quot(a[1] - a[3], r);
                end
                1: begin
                    q[1] = sat_one(r);
                    q[0] = quot(a[5] - a[7], r);
                    q[2] = quot(a[1] + a[3], r);
                    q[3] = quot(a[2] + a[6], r);
                end
                2: begin
                    q[2] = sat_one(r);
                    q[0] = quot(a[6] - a[2], r);
                    q[1] = quot(a[3] + a[1], r);
                    q[3] = quot(a[7] + a[5], r);
                end
                default: begin
                    q[3] = sat_one(r);
                    q[0] = quot(a[1] - a[3], r);
                    q[1] = quot(a[6] + a[2], r);
                    q[2] = quot(a[7] + a[5], r);
                end
            endcase
        end
        res.qw = q[0][15:0];
        res.qx = q[1][15:0];
        res.qy = q[2][15:0];
        res.qz = q[3][15:0];
        res.pick = rmq_pkg::case_t'(sel[1:0]);
        return res;
    endfunction

    always_ff @(posedge aclk) begin
        quat_t want;
        if (!aresetn) begin
            fail_count   <= 0;
            results_seen <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                quat_queue.push_back(convert_matrix(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (quat_queue.size() == 0) begin
                    $error("unexpected item: tdata %h tuser %h", m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    want = quat_queue.pop_front();
                    if (m_tdata[15:0] !== want.qw || m_tdata[31:16] !== want.qx ||
                        m_tdata[47:32] !== want.qy || m_tdata[63:48] !== want.qz ||
                        m_tuser[1:0] !== want.pick || m_tuser[2] !== want.bad) begin
                        fail_count <= fail_count + 1;
                        if (m_tdata[15:0] !== want.qw)
                            $error("quat_w: expected %h, got %h", want.qw, m_tdata[15:0]);
                        if (m_tdata[31:16] !== want.qx)
                            $error("quat_x: expected %h, got %h", want.qx, m_tdata[31:16]);
                        if (m_tdata[47:32] !== want.qy)
                            $error("quat_y: expected %h, got %h", want.qy, m_tdata[47:32]);
                        if (m_tdata[63:48] !== want.qz)
                            $error("quat_z: expected %h, got %h", want.qz, m_tdata[63:48]);
                        if (m_tuser[1:0] !== want.pick)
                            $error("largest_case: expected %0d, got %0d", want.pick,
                                   m_tuser[1:0]);
                        if (m_tuser[2] !== want.bad)
                            $error("invalid: expected %0d, got %0d", want.bad, m_tuser[2]);
                    end
                end
            end
        end
    end

    assign pending = quat_queue.size();

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion testbench
// Drives directed and random matrices through the block with random gaps and
// stalls on both channels, and gives the verdict from the checker's count.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY   = 47;
    localparam int WATCHDOG  = 5000;
    localparam int N_RANDOM  = 690;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [143:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [63:0]   m_tdata;
    logic [2:0]    m_tuser;

    int fail_count;
    int pending;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;
    int items_sent;
    int n_invalid;

    rotation_matrix_to_quaternion i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rmq_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [143:0] pack_matrix(int e[9]);
        logic [143:0] d;
        for (int i = 0; i < 9; i++) begin
            d[16*i +: 16] = e[i][15:0];
        end
        return d;
    endfunction

    // Sends one item, with a random gap before it; valid stays high across
    // back-to-back items.
    task automatic send_matrix(logic [143:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_entries(int e[9]);
        send_matrix(pack_matrix(e));
    endtask

    function automatic int near_rot(int v);
        return v + $urandom_range(64) - 32;
    endfunction

    // A rotation about one axis with a small random error on each entry, so every
    // case is reached with realistic data.
    task automatic send_rotation();
        int e[9];
        int c;
        int s;
        int ax;
        ax = $urandom_range(2);
        c = $urandom_range(32767) - 16384;
        s = $urandom_range(32767) - 16384;
        if ($urandom_range(1)) begin
            c = -(16384 - $urandom_range(400));
            s = $urandom_range(800) - 400;
        end
        e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        case (ax)
            0: begin
                e[4] = c; e[8] = c; e[5] = s; e[7] = -s;
            end
            1: begin
                e[0] = c; e[8] = c; e[6] = s; e[2] = -s;
            end
            default: begin
                e[0] = c; e[4] = c; e[1] = s; e[3] = -s;
            end
        endcase
        for (int i = 0; i < 9; i++) begin
            e[i] = near_rot(e[i]);
            if (e[i] > 32767) e[i] = 32767;
            if (e[i] < -32768) e[i] = -32768;
        end
        send_entries(e);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        int e[9];
        int phase_len;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        idle_cycles   = 0;
        items_sent    = 0;
        n_invalid     = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Identity, half-turns about each axis and extreme matrices.
        send_entries('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
        send_entries('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
        send_entries('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
        send_entries('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
        send_entries('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_entries('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
        send_entries('{-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                       -32768, -32768});
        send_entries('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                       -32768});
        send_entries('{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
                       32767});
        // Ties between combinations: lower case wins.
        send_entries('{0, 100, 200, 300, 0, 400, 500, 600, 0});
        send_entries('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
        // Diagonal matrices with entries one count apart.
        send_entries('{-5462, 0, 0, 0, -5461, 0, 0, 0, -5461});
        send_entries('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16385});
        send_entries('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16383});
        // Large off-diagonal entries, then identity with tiny off-diagonals.
        send_entries('{-16383, 32767, -32768, -32768, -16383, 32767, 32767, -32768,
                       16383});
        send_entries('{16384, 1, -1, -1, 16384, 1, 1, -1, 16384});

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 82 : 0;
            recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 9 : 0;
            phase_len = N_RANDOM / 3;
            for (int k = 0; k < phase_len; k++) begin
                if (k == phase_len / 2) begin
                    wait_drained();
                end
                if ($urandom_range(99) < 70) begin
                    send_rotation();
                end else begin
                    for (int i = 0; i < 9; i++) begin
                        e[i] = $urandom_range(65535) - 32768;
                    end
                    send_entries(e);
                end
            end
        end
        recv_idle_pct = 0;
        wait_drained();
        repeat (LATENCY) @(negedge aclk);

        $display("Sent %0d matrices (directed, near-rotations, random noise), %0d returned.",
                 items_sent, results_seen);
        $display("Covered idle and stalled traffic on both channels and a full drain.");
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
